// ===== rtl/core/cps_pkg.sv =====
// ----------------------------------------------------------------------------
// Chebyshev series package
// Widths and fixed-point constants shared by the channel interfaces and core.
// ----------------------------------------------------------------------------
package cps_pkg;

    localparam int MAX_DEGREE = 63;
    localparam int FRAC_BITS  = 16;

    localparam int IDX_W = $clog2(MAX_DEGREE + 1);
    localparam int X_W   = FRAC_BITS + 2;
    localparam int P_W   = 32;
    localparam int PROD_W = X_W + P_W;
    localparam int Q_W    = PROD_W - FRAC_BITS + 1;
    localparam int DIFF_W = Q_W + 1;

    localparam logic [IDX_W-1:0] DEG_LIMIT = IDX_W'(MAX_DEGREE);

    localparam logic signed [X_W-1:0]    X_ONE     = X_W'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [X_W-1:0]    X_NEG_ONE = -X_ONE;
    localparam logic signed [P_W-1:0]    P_ONE     = P_W'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'sd1 <<< (FRAC_BITS - 2));

    localparam logic signed [DIFF_W-1:0] SAT_HI = DIFF_W'(64'sd2147483647);
    localparam logic signed [DIFF_W-1:0] SAT_LO = -DIFF_W'(64'sd2147483648);

endpackage

// ===== rtl/core/cps_channels.sv =====
// ----------------------------------------------------------------------------
// Chebyshev series channels
// Valid/ready channels for the request item and for each result transfer.
// ----------------------------------------------------------------------------
interface cps_req_if;

    logic                             valid;
    logic                             ready;
    logic                             func;
    logic [cps_pkg::IDX_W-1:0]        degree;
    logic signed [cps_pkg::X_W-1:0]   x_value;

    modport source (output valid, output func, output degree, output x_value, input ready);
    modport sink   (input valid, input func, input degree, input x_value, output ready);

endinterface

interface cps_rsp_if;

    logic                             valid;
    logic                             ready;
    logic [cps_pkg::IDX_W-1:0]        order_index;
    logic signed [cps_pkg::P_W-1:0]   poly_value;
    logic                             last;

    modport source (output valid, output order_index, output poly_value, output last,
                    input ready);
    modport sink   (input valid, input order_index, input poly_value, input last,
                    output ready);

endinterface

// ===== rtl/core/chebyshev_polynomial_series_core.sv =====
// ----------------------------------------------------------------------------
// Chebyshev polynomial series core
// Microcoded generator of T_0..T_n or U_0..U_n by the three-term recurrence.
// ----------------------------------------------------------------------------
// Usage:
// A request on req carries the kind (func), the highest degree and the
// abscissa x in signed fixed point; x is clamped to [-1, 1]. The core answers
// with degree + 1 result transfers on rsp, in order of degree, with last set on
// the final one. Values are saturated to the signed 32-bit range.
// One request is processed at a time; req.ready is high only while the
// sequencer sits at its fetch step. A request transfer moves the sequencer to
// its first emitting step, which registers the degree 0 result. Degrees 0 and
// 1 take one emitting step each, every further degree takes a multiply step
// and a combine step through the single multiplier; after the last degree the
// sequencer returns to fetch. A stalled receiver holds the result register and the
// sequencer waits at the next emitting step. Reset returns the sequencer to
// fetch and empties the result register.
// ----------------------------------------------------------------------------
module chebyshev_polynomial_series_core
(
    input  logic          clk,
    input  logic          rst_n,
    cps_req_if.sink       req,
    cps_rsp_if.source     rsp
);

    typedef enum logic [2:0] {
        UPC_FETCH,
        UPC_EMIT0,
        UPC_EMIT1,
        UPC_MUL,
        UPC_REC
    } upc_t;

    typedef enum logic [1:0] {
        SRC_ONE,
        SRC_START,
        SRC_REC
    } src_t;

    typedef struct packed {
        logic wait_in;
        logic emit;
        src_t src;
        logic mul_en;
        logic end_on_last;
        logic jump;
        upc_t target;
    } ctl_word_t;

    function automatic ctl_word_t rom_word(input upc_t addr);
        ctl_word_t w;
        w = '{wait_in: 1'b0, emit: 1'b0, src: SRC_ONE, mul_en: 1'b0,
              end_on_last: 1'b0, jump: 1'b0, target: UPC_FETCH};
        unique case (addr)
            UPC_FETCH: w.wait_in = 1'b1;
            UPC_EMIT0:
            begin
                w.emit        = 1'b1;
                w.src         = SRC_ONE;
                w.end_on_last = 1'b1;
            end
            UPC_EMIT1:
            begin
                w.emit        = 1'b1;
                w.src         = SRC_START;
                w.end_on_last = 1'b1;
            end
            UPC_MUL: w.mul_en = 1'b1;
            UPC_REC:
            begin
                w.emit        = 1'b1;
                w.src         = SRC_REC;
                w.end_on_last = 1'b1;
                w.jump        = 1'b1;
                w.target      = UPC_MUL;
            end
            default: w.jump = 1'b1;
        endcase
        return w;
    endfunction

    upc_t                               upc_reg, upc_next;
    logic                               kind_reg;
    logic [cps_pkg::IDX_W-1:0]          n_reg, idx_reg;
    logic signed [cps_pkg::X_W-1:0]     x_reg;
    logic signed [cps_pkg::P_W-1:0]     p1_reg, p2_reg;
    logic signed [cps_pkg::PROD_W-1:0]  prod_reg;

    logic                               out_valid_reg, out_valid_next;
    logic [cps_pkg::IDX_W-1:0]          out_idx_reg;
    logic signed [cps_pkg::P_W-1:0]     out_val_reg;
    logic                               out_last_reg;

    ctl_word_t                          ctl;
    logic                               emit_ok, advance, last_w;
    logic signed [cps_pkg::X_W-1:0]     x_clamp;
    logic [cps_pkg::IDX_W-1:0]          n_clamp;
    logic signed [cps_pkg::P_W-1:0]     start_w, rec_w, val_w;
    logic signed [cps_pkg::PROD_W-1:0]  rnd_sum;
    logic signed [cps_pkg::Q_W-1:0]     rnd_q;
    logic signed [cps_pkg::DIFF_W-1:0]  diff;

    assign ctl     = rom_word(upc_reg);
    assign emit_ok = !out_valid_reg || rsp.ready;
    assign advance = (!ctl.wait_in || req.valid) && (!ctl.emit || emit_ok);
    assign last_w  = (idx_reg == n_reg);

    always_comb
    begin
        if (req.x_value > cps_pkg::X_ONE)
            x_clamp = cps_pkg::X_ONE;
        else if (req.x_value < cps_pkg::X_NEG_ONE)
            x_clamp = cps_pkg::X_NEG_ONE;
        else
            x_clamp = req.x_value;
        n_clamp = (req.degree > cps_pkg::DEG_LIMIT) ? cps_pkg::DEG_LIMIT : req.degree;
    end

    always_comb
    begin
        if (kind_reg)
            start_w = cps_pkg::P_W'(x_reg) <<< 1;
        else
            start_w = cps_pkg::P_W'(x_reg);
        rnd_sum = prod_reg + cps_pkg::ROUND_HALF;
        rnd_q   = $signed(rnd_sum[cps_pkg::PROD_W-1:cps_pkg::FRAC_BITS-1]);
        diff    = cps_pkg::DIFF_W'(rnd_q) - cps_pkg::DIFF_W'(p2_reg);
        if (diff > cps_pkg::SAT_HI)
            rec_w = cps_pkg::P_W'(cps_pkg::SAT_HI);
        else if (diff < cps_pkg::SAT_LO)
            rec_w = cps_pkg::P_W'(cps_pkg::SAT_LO);
        else
            rec_w = cps_pkg::P_W'(diff);
        case (ctl.src)
            SRC_ONE:   val_w = cps_pkg::P_ONE;
            SRC_START: val_w = start_w;
            default:   val_w = rec_w;
        endcase
    end

    always_comb
    begin
        upc_next = upc_reg;
        if (advance)
        begin
            if (ctl.end_on_last && last_w)
                upc_next = UPC_FETCH;
            else if (ctl.jump)
                upc_next = ctl.target;
            else
                upc_next = upc_t'(upc_reg + 3'd1);
        end
        out_valid_next = out_valid_reg && !rsp.ready;
        if (advance && ctl.emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= UPC_FETCH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && ctl.wait_in)
        begin
            x_reg    <= x_clamp;
            n_reg    <= n_clamp;
            kind_reg <= req.func;
            idx_reg  <= '0;
        end
        if (advance && ctl.mul_en)
            prod_reg <= x_reg * p1_reg;
        if (advance && ctl.emit)
        begin
            idx_reg      <= idx_reg + 1'b1;
            out_idx_reg  <= idx_reg;
            out_val_reg  <= val_w;
            out_last_reg <= last_w;
            case (ctl.src)
                SRC_ONE:   p2_reg <= val_w;
                SRC_START: p1_reg <= val_w;
                default:
                begin
                    p2_reg <= p1_reg;
                    p1_reg <= val_w;
                end
            endcase
        end
    end

    assign req.ready       = ctl.wait_in;
    assign rsp.valid       = out_valid_reg;
    assign rsp.order_index = out_idx_reg;
    assign rsp.poly_value  = out_val_reg;
    assign rsp.last        = out_last_reg;

`ifndef SYNTHESIS
    a_fetch_to_emit0: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (upc_reg == UPC_EMIT0 && idx_reg == '0))
        else $error("Sequencer did not start at the first result step.");

    a_last_to_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && ctl.emit && last_w) |=> (upc_reg == UPC_FETCH && rsp.last))
        else $error("Sequencer did not return to fetch after the last result.");

    a_degree_zero_one: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.order_index == '0) |-> (rsp.poly_value == cps_pkg::P_ONE))
        else $error("Degree zero result is not one.");

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg != UPC_FETCH) |-> (idx_reg <= n_reg))
        else $error("Result index ran past the requested degree.");
`endif

endmodule
